// File: src/ppes_pkg.sv
// ----------------------------------------------------------------------------
// ppes_pkg
// Shared types and constants for the pair potential energy sum block.
// ----------------------------------------------------------------------------
`default_nettype none
package ppes_pkg;

  localparam int unsigned NUM_W    = 96;
  localparam logic [31:0] G_RESET  = 32'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_SQRT,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic sq;
    logic sqrt_init;
    logic sqrt_step;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_init;
    logic div_step;
    logic acc;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic sq_done;
    logic sqrt_done;
    logic div_done;
    logic last;
  } stat_t;

endpackage
`default_nettype wire

// File: src/ppes_ctrl.sv
// ----------------------------------------------------------------------------
// ppes_ctrl
// Sequencer for one pair: difference, squares, root, products, divide, sum, and output after the last pair.
// ----------------------------------------------------------------------------
`default_nettype none
module ppes_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  ppes_pkg::stat_t  stat,
  output ppes_pkg::cmd_t   cmd
);

  ppes_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ppes_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ppes_pkg::ST_DIFF;
        end
      end
      ppes_pkg::ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ppes_pkg::ST_SQ;
      end
      ppes_pkg::ST_SQ: begin
        cmd.sq = 1'b1;
        if (stat.sq_done) begin
          cmd.sqrt_init = 1'b1;
          state_next    = ppes_pkg::ST_SQRT;
        end
      end
      ppes_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_done) begin
          state_next = ppes_pkg::ST_MUL1;
        end
      end
      ppes_pkg::ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ppes_pkg::ST_MUL2;
      end
      ppes_pkg::ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ppes_pkg::ST_MUL3;
      end
      ppes_pkg::ST_MUL3: begin
        cmd.mul3     = 1'b1;
        cmd.div_init = 1'b1;
        state_next   = ppes_pkg::ST_DIV;
      end
      ppes_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = ppes_pkg::ST_ACC;
        end
      end
      ppes_pkg::ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = stat.last ? ppes_pkg::ST_OUT : ppes_pkg::ST_IDLE;
      end
      ppes_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear  = 1'b1;
          state_next = ppes_pkg::ST_IDLE;
        end
      end
      default: state_next = ppes_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/ppes_dp.sv
// ----------------------------------------------------------------------------
// ppes_dp
// Datapath: squared separation, bitwise root, G*m1*m2, restoring divide,
// saturating sum with sticky flags.
// ----------------------------------------------------------------------------
`default_nettype none
module ppes_dp #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  ppes_pkg::cmd_t           cmd,
  output ppes_pkg::stat_t          stat,
  input  wire [31:0]               grav_constant,
  input  wire [31:0]               ax,
  input  wire [31:0]               ay,
  input  wire [31:0]               az,
  input  wire [31:0]               bx,
  input  wire [31:0]               by,
  input  wire [31:0]               bz,
  input  wire [31:0]               m1,
  input  wire [31:0]               m2,
  input  wire                      last_in,
  output logic [63:0]              energy,
  output logic                     sat_flag,
  output logic                     coin_flag
);

  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned R2W = SQW + 2;
  localparam int unsigned RTW = (R2W + 1) / 2;
  localparam int unsigned RCW = $clog2(RTW + 1);
  localparam int unsigned DCW = $clog2(ppes_pkg::NUM_W + 1);

  logic signed [COORD_WIDTH-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic [31:0]       m1_r, m2_r;
  logic              last_r;
  logic [DW-1:0]     d0, d1, d2;
  logic [1:0]        sq_idx;
  logic [R2W-1:0]    r2;
  logic [R2W-1:0]    rem_s;
  logic [RTW-1:0]    root;
  logic [RCW-1:0]    rcnt;
  logic [63:0]       gm;
  logic [ppes_pkg::NUM_W-1:0] num;
  logic [ppes_pkg::NUM_W-1:0] quo;
  logic [RTW:0]      rem_d;
  logic [DCW-1:0]    dcnt;
  logic              zero_r2;

  logic signed [DW-1:0] df [3];
  logic [DW-1:0]     sq_op;
  logic [SQW-1:0]    sq_prod;
  logic [R2W-1:0]    trial;
  logic [RTW+1:0]    rsh;
  logic [RTW+1:0]    dsub;
  logic [64:0]       room;

  assign df[0] = DW'(ax_r) - DW'(bx_r);
  assign df[1] = DW'(ay_r) - DW'(by_r);
  assign df[2] = DW'(az_r) - DW'(bz_r);

  always_comb begin
    case (sq_idx)
      2'd0:    sq_op = d0;
      2'd1:    sq_op = d1;
      default: sq_op = d2;
    endcase
  end
  assign sq_prod = SQW'(sq_op) * SQW'(sq_op);

  // one root bit per step: test (4*root+1) << 2k against remainder
  assign trial = ((R2W'(root) << 2) | R2W'(1)) << (2 * (RTW - 1 - rcnt));

  assign rsh  = {rem_d, num[ppes_pkg::NUM_W-1]};
  assign dsub = rsh - (RTW+2)'(root);
  assign room = 65'(energy ^ {1'b1, 63'd0});

  assign stat.sq_done   = (sq_idx == 2'd2);
  assign stat.sqrt_done = (rcnt == RCW'(RTW - 1));
  assign stat.div_done  = (dcnt == DCW'(ppes_pkg::NUM_W - 1));
  assign stat.last      = last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r   <= COORD_WIDTH'(ax); ay_r <= COORD_WIDTH'(ay); az_r <= COORD_WIDTH'(az);
      bx_r   <= COORD_WIDTH'(bx); by_r <= COORD_WIDTH'(by); bz_r <= COORD_WIDTH'(bz);
      m1_r   <= m1; m2_r <= m2;
      last_r <= last_in;
      sq_idx <= 2'd0;
      r2     <= '0;
    end
    if (cmd.sqrt_init) begin
      r2      <= r2 + R2W'(sq_prod);
      rem_s   <= r2 + R2W'(sq_prod);
      zero_r2 <= (r2 + R2W'(sq_prod)) == '0;
      root    <= '0;
      rcnt    <= '0;
    end else if (cmd.sq) begin
      r2     <= r2 + R2W'(sq_prod);
      sq_idx <= sq_idx + 2'd1;
    end
    if (cmd.sqrt_step) begin
      if (rem_s >= trial) begin
        rem_s <= rem_s - trial;
        root  <= (root << 1) | RTW'(1);
      end else begin
        root <= root << 1;
      end
      rcnt <= rcnt + RCW'(1);
    end
    if (cmd.mul1) begin
      gm <= 64'(grav_constant) * 64'(m1_r);
    end
    if (cmd.mul2) begin
      num <= ppes_pkg::NUM_W'(64'(gm[31:0]) * 64'(m2_r));
    end
    if (cmd.mul3) begin
      num <= num + (ppes_pkg::NUM_W'(64'(gm[63:32]) * 64'(m2_r)) << 32);
    end
    if (cmd.div_init) begin
      rem_d <= '0;
      quo   <= '0;
      dcnt  <= '0;
    end
    if (cmd.div_step) begin
      num  <= num << 1;
      dcnt <= dcnt + DCW'(1);
      if (!dsub[RTW+1]) begin
        rem_d <= dsub[RTW:0];
        quo   <= {quo[ppes_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_d <= rsh[RTW:0];
        quo   <= {quo[ppes_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  // absolute differences, registered before the squaring multiplier
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      d0 <= df[0][DW-1] ? DW'(-df[0]) : DW'(df[0]);
      d1 <= df[1][DW-1] ? DW'(-df[1]) : DW'(df[1]);
      d2 <= df[2][DW-1] ? DW'(-df[2]) : DW'(df[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      energy    <= '0;
      sat_flag  <= 1'b0;
      coin_flag <= 1'b0;
    end else if (cmd.acc) begin
      if (zero_r2) begin
        coin_flag <= 1'b1;
      end else if (quo[ppes_pkg::NUM_W-1:64] != '0 || 65'(quo[63:0]) > room) begin
        energy   <= {1'b1, 63'd0};
        sat_flag <= 1'b1;
      end else begin
        energy <= energy - quo[63:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/pair_potential_energy_sum.sv
// ----------------------------------------------------------------------------
// pair_potential_energy_sum
// Sums -G*m1*m2/d over particle pairs; emits the total on the last pair.
//
// channel   dir  fields
// cfg       in   cfg_data = grav_constant
// s_axis    in   tdata = pos x/y/z first, pos x/y/z second, m1, m2; tlast
// m_axis    out  tdata = potential_energy; tuser = sum_saturated, coincident
//
// One pair at a time; a new pair is accepted only after the previous one is summed.
// A bitwise square root (one bit a cycle, COORD_WIDTH+2 steps) and a 96-step
// restoring divider set the time per pair. A last pair then goes to an output
// state that waits for m_axis_tready. Synchronous reset clears the sum and
// flags and sets G to 1.0. The result holds until m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none
module pair_potential_energy_sum #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire [31:0]   cfg_data,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // first_pos_x/y/z, second_pos_x/y/z, first_mass, second_mass (32 b each)
  input  wire [255:0]  s_axis_tdata,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // potential_energy
  output logic [63:0]  m_axis_tdata,
  // sum_saturated, coincident_seen
  output logic [1:0]   m_axis_tuser
);

  ppes_pkg::cmd_t  cmd;
  ppes_pkg::stat_t stat;
  logic [31:0]     grav;
  logic            sat_flag, coin_flag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav <= ppes_pkg::G_RESET;
    end else if (cfg_valid) begin
      grav <= cfg_data;
    end
  end

  ppes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ppes_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .grav_constant (grav),
    .ax            (s_axis_tdata[31:0]),
    .ay            (s_axis_tdata[63:32]),
    .az            (s_axis_tdata[95:64]),
    .bx            (s_axis_tdata[127:96]),
    .by            (s_axis_tdata[159:128]),
    .bz            (s_axis_tdata[191:160]),
    .m1            (s_axis_tdata[223:192]),
    .m2            (s_axis_tdata[255:224]),
    .last_in       (s_axis_tlast),
    .energy        (m_axis_tdata),
    .sat_flag      (sat_flag),
    .coin_flag     (coin_flag)
  );

  assign m_axis_tuser = {coin_flag, sat_flag};

endmodule
`default_nettype wire

// File: dv/tb_pair_potential_energy_sum.sv
// ----------------------------------------------------------------------------
// tb_pair_potential_energy_sum
// Self-checking bench for the pair potential energy sum block. Drives pair
// sets with random and corner coordinates, masses and G settings, predicts
// the signed saturating energy total per set and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_pair_potential_energy_sum;

  localparam int unsigned CW        = 32;
  localparam int unsigned WDOG_MAX  = 20000;

  typedef struct {
    logic [31:0] p1 [3];
    logic [31:0] p2 [3];
    logic [31:0] m1;
    logic [31:0] m2;
    logic        last;
  } pair_t;

  typedef struct {
    logic [63:0] energy;
    logic        sat;
    logic        coinc;
  } total_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [31:0]   cfg_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [255:0]  s_axis_tdata = '0;
  logic          s_axis_tlast = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [63:0]   m_axis_tdata;
  logic [1:0]    m_axis_tuser;

  // predictor state
  logic [31:0]   g_reg = ppes_pkg::G_RESET;
  logic [63:0]   acc_sum = '0;
  logic          acc_sat = 1'b0;
  logic          acc_coinc = 1'b0;

  total_t        totals_q [$];
  int            errors = 0;
  int            pairs_sent = 0;
  int            totals_seen = 0;
  int            idle_send_pct = 0;
  int            idle_recv_pct = 0;
  int            wdog = 0;

  always #5 clk = ~clk;

  pair_potential_energy_sum #(.COORD_WIDTH(CW)) i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  function automatic logic [63:0] isqrt100(logic [99:0] v);
    logic [99:0] rem;
    logic [99:0] res;
    logic [99:0] b;
    logic [99:0] t;
    rem = v;
    res = '0;
    b = 100'd1 << 98;
    while (b != 0) begin
      t = res + b;
      if (rem >= t) begin
        rem = rem - t;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[63:0];
  endfunction

  task automatic accumulate_pair(pair_t p);
    logic signed [32:0] d;
    logic [99:0] r2;
    logic [63:0] sep;
    logic [127:0] num;
    logic [127:0] term;
    logic [63:0] room;
    total_t t;
    r2 = '0;
    for (int k = 0; k < 3; k++) begin
      d = $signed(p.p1[k]) - $signed(p.p2[k]);
      if (d < 0) d = -d;
      r2 += 100'(d[32:0]) * 100'(d[32:0]);
    end
    if (r2 == 0) begin
      acc_coinc = 1'b1;
    end else begin
      sep = isqrt100(r2);
      num = 128'(g_reg) * 128'(p.m1) * 128'(p.m2);
      term = num / 128'(sep);
      room = acc_sum ^ 64'h8000_0000_0000_0000;
      if (term[127:64] != 0 || term[63:0] > room) begin
        acc_sum = 64'h8000_0000_0000_0000;
        acc_sat = 1'b1;
      end else begin
        acc_sum = acc_sum - term[63:0];
      end
    end
    if (p.last) begin
      t.energy = acc_sum;
      t.sat = acc_sat;
      t.coinc = acc_coinc;
      totals_q.push_back(t);
      acc_sum = '0;
      acc_sat = 1'b0;
      acc_coinc = 1'b0;
    end
  endtask

  // entered and left at a falling edge; valid stays up until the next call
  task automatic send_pair(pair_t p);
    while (($urandom_range(99, 0)) < idle_send_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= {p.m2, p.m1, p.p2[2], p.p2[1], p.p2[0], p.p1[2], p.p1[1], p.p1[0]};
    s_axis_tlast <= p.last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    accumulate_pair(p);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (totals_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_g(logic [31:0] val);
    wait_drained();
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    g_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int sel);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(2000, 0)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic pair_t rand_pair(logic last);
    pair_t p;
    int sel;
    sel = $urandom_range(9, 0);
    for (int k = 0; k < 3; k++) begin
      p.p1[k] = rand_coord(sel < 2 ? $urandom_range(3, 0) : 3 - (sel & 1));
      p.p2[k] = ($urandom_range(19, 0) == 0) ? p.p1[k] : rand_coord($urandom_range(3, 0));
    end
    p.m1 = ($urandom_range(7, 0) == 0) ? 32'hffff_ffff : $urandom_range(32'h0004_0000, 0);
    p.m2 = ($urandom_range(7, 0) == 0) ? $urandom() : $urandom_range(32'h0004_0000, 0);
    p.last = last;
    return p;
  endfunction

  function automatic pair_t make_pair(logic [31:0] a, logic [31:0] b,
                                      logic [31:0] m1, logic [31:0] m2, logic last);
    pair_t p;
    for (int k = 0; k < 3; k++) begin
      p.p1[k] = a;
      p.p2[k] = b;
    end
    p.m1 = m1;
    p.m2 = m2;
    p.last = last;
    return p;
  endfunction

  task automatic test_directed();
    send_pair(make_pair(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1));
    send_pair(make_pair(32'h1234_5678, 32'h1234_5678, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
    send_pair(make_pair(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0));
    send_pair(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 1'b1));
    send_pair(make_pair(32'h0000_0001, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b0));
    send_pair(make_pair(32'h0000_0001, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b0));
    send_pair(make_pair(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1));
    send_pair(make_pair(32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 1'b1));
    send_pair(make_pair(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1));
  endtask

  task automatic test_random_sets(int n_pairs);
    int left;
    int len;
    left = n_pairs;
    while (left > 0) begin
      len = ($urandom_range(3, 0) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) send_pair(rand_pair(i == len - 1));
      left -= len;
    end
  endtask

  task automatic test_g_settings();
    write_g(32'h0000_0000);
    test_random_sets(40);
    write_g(32'hffff_ffff);
    test_random_sets(40);
    write_g($urandom());
    test_random_sets(40);
    write_g(ppes_pkg::G_RESET);
  endtask

  task automatic test_pause_until_drained();
    test_random_sets(10);
    wait_drained();
    test_random_sets(10);
  endtask

  // result checker
  always @(posedge clk) begin
    total_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      totals_seen++;
      if (totals_q.size() == 0) begin
        $error("unexpected result energy=%h", m_axis_tdata);
        errors++;
      end else begin
        e = totals_q.pop_front();
        if (m_axis_tdata !== e.energy) begin
          $error("potential_energy exp %h got %h", e.energy, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== e.sat) begin
          $error("sum_saturated exp %b got %b", e.sat, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== e.coinc) begin
          $error("coincident_seen exp %b got %b", e.coinc, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99, 0) >= idle_recv_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("tb_pair_potential_energy_sum failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_send_pct = 7;
    idle_recv_pct = 52;
    test_directed();
    test_random_sets(300);
    test_g_settings();
    idle_send_pct = 52;
    idle_recv_pct = 7;
    test_pause_until_drained();
    test_random_sets(250);
    idle_send_pct = 0;
    idle_recv_pct = 0;
    test_random_sets(250);
    wait_drained();
    $display("covered %0d pairs, %0d set totals, G at zero, max, random and 1.0",
             pairs_sent, totals_seen);
    if (errors == 0 && totals_q.size() == 0)
      $display("tb_pair_potential_energy_sum passed");
    else
      $display("tb_pair_potential_energy_sum failed");
    $finish;
  end

endmodule
`default_nettype wire
